@@ src/btlv_pkg.sv @@
// ----------------------------------------------------------------------------
// btlv_pkg - shared types and constants for the BER TLV stream parser
// Byte item, result item, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package btlv_pkg;

    localparam int POSITION_BITS_DEF    = 16;
    localparam int MAX_LENGTH_BYTES_DEF = 4;

    localparam logic [7:0] LONG_FORM_MARK = 8'h80;

    localparam int TAG_BITS    = 8;
    localparam int LENGTH_BITS = 31;
    localparam int OFFSET_BITS = 16;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_TRUNC = 2'd1,
        ST_UNSUP = 2'd2
    } status_t;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic                   buffer_end;
        logic [OFFSET_BITS-1:0] content_offset;
        logic [LENGTH_BITS-1:0] content_length;
        logic [TAG_BITS-1:0]    tag;
        status_t                status;
    } result_t;

endpackage

@@ src/ber_tlv_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser_unit - BER TLV element splitter for a byte stream
// Splits each buffer into tag-length-value elements and reports completed
// elements, truncation and unsupported length forms.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                  tuser      tlast
//  s_       in   [7:0] data_byte                     -          last_byte
//  m_       out  [7:0] tag, [38:8] content_length,   [1:0]      buffer_end
//                [54:39] content_offset, pad zeros   status
//
//  One byte per cycle while the m_ side is not stalled; s_ to m_ passes
//  the input register, then header logic into the result register.
//  aresetn clears parse state: expect tag, position zero.
//  A stalled m_ side holds the result register; s_tready drops only when
//  both registers are full and m_tready is low.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_unit #(
    parameter int POSITION_BITS    = btlv_pkg::POSITION_BITS_DEF,
    parameter int MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] tag, [38:8] content_length, [54:39] content_offset
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import btlv_pkg::*;

    localparam int IN_W  = $bits(in_item_t);
    localparam int RES_W = $bits(result_t);

    in_item_t s_item, core_item;
    result_t  core_res, m_res;
    logic     core_valid, core_take, res_valid, out_in_ready;
    logic [IN_W-1:0]  core_item_bits;
    logic [RES_W-1:0] m_res_bits;

    assign s_item.data_byte = s_tdata;
    assign s_item.last_byte = s_tlast;

    btlv_stage #(.W(IN_W)) u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_item),
        .out_valid (core_valid),
        .out_ready (out_in_ready),
        .out_data  (core_item_bits)
    );

    assign core_item = in_item_t'(core_item_bits);
    assign core_take = core_valid && out_in_ready;

    btlv_core #(
        .POSITION_BITS    (POSITION_BITS),
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (core_take),
        .item      (core_item),
        .res_valid (res_valid),
        .res       (core_res)
    );

    btlv_stage #(.W(RES_W)) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (out_in_ready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res_bits)
    );

    assign m_res   = result_t'(m_res_bits);
    assign m_tdata = {1'b0, m_res.content_offset, m_res.content_length, m_res.tag};
    assign m_tuser = m_res.status;
    assign m_tlast = m_res.buffer_end;

endmodule

@@ src/btlv_stage.sv @@
// ----------------------------------------------------------------------------
// btlv_stage - registered valid/ready stage
// Holds one transaction; accepts a new one when empty or as the held one leaves.
// ----------------------------------------------------------------------------
module btlv_stage #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

endmodule

@@ src/btlv_core.sv @@
// ----------------------------------------------------------------------------
// btlv_core - TLV header state machine
// Tracks tag, length form and content count; forms at most one result per byte.
// ----------------------------------------------------------------------------
module btlv_core #(
    parameter int POSITION_BITS    = btlv_pkg::POSITION_BITS_DEF,
    parameter int MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  btlv_pkg::in_item_t item,
    output logic               res_valid,
    output btlv_pkg::result_t  res
);
    import btlv_pkg::*;

    localparam int LEN_BITS   = 8 * MAX_LENGTH_BYTES;
    localparam int CNT_BITS   = $clog2(MAX_LENGTH_BYTES + 1);
    localparam bit TOP_CHECK  = (LEN_BITS == 32);
    localparam logic [8:0] LONG_MAX = 9'(LONG_FORM_MARK) + 9'(MAX_LENGTH_BYTES);

    typedef enum logic [2:0] {
        PH_TAG       = 3'd0,
        PH_LEN       = 3'd1,
        PH_LEN_BYTES = 3'd2,
        PH_CONTENT   = 3'd3,
        PH_SKIP      = 3'd4
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [7:0]               tag_reg, tag_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [LEN_BITS-1:0]      acc_reg, acc_next;
    logic [LEN_BITS-1:0]      left_reg, left_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;

    logic [7:0]               b;
    logic                     last;
    logic [LEN_BITS-1:0]      acc_sh;
    logic [LEN_BITS-1:0]      known_len;
    logic                     known;
    logic [POSITION_BITS-1:0] pos_inc;

    assign b       = item.data_byte;
    assign last    = item.last_byte;
    assign acc_sh  = LEN_BITS'({acc_reg, b});
    assign pos_inc = pos_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        start_next = start_reg;
        known      = 1'b0;
        known_len  = acc_reg;

        res_valid          = 1'b0;
        res.status         = ST_DONE;
        res.content_length = '0;
        res.content_offset = '0;
        res.buffer_end     = last;

        case (phase_reg)
            PH_TAG: begin
                tag_next   = b;
                phase_next = PH_LEN;
                if (last) begin
                    res_valid  = 1'b1;
                    res.status = ST_TRUNC;
                end
            end
            PH_LEN: begin
                if (b < LONG_FORM_MARK) begin
                    acc_next  = LEN_BITS'(b);
                    known_len = LEN_BITS'(b);
                    known     = 1'b1;
                end else if (b == LONG_FORM_MARK || 9'(b) > LONG_MAX) begin
                    res_valid  = 1'b1;
                    res.status = ST_UNSUP;
                    phase_next = PH_SKIP;
                end else begin
                    cnt_next   = CNT_BITS'(b - LONG_FORM_MARK);
                    acc_next   = '0;
                    phase_next = PH_LEN_BYTES;
                    if (last) begin
                        res_valid  = 1'b1;
                        res.status = ST_TRUNC;
                    end
                end
            end
            PH_LEN_BYTES: begin
                acc_next = acc_sh;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_next == '0) begin
                    if (TOP_CHECK && acc_sh[LEN_BITS-1]) begin
                        res_valid  = 1'b1;
                        res.status = ST_UNSUP;
                        phase_next = PH_SKIP;
                    end else begin
                        known_len = acc_sh;
                        known     = 1'b1;
                    end
                end else if (last) begin
                    res_valid  = 1'b1;
                    res.status = ST_TRUNC;
                end
            end
            PH_CONTENT: begin
                left_next = left_reg - 1'b1;
                if (left_reg == LEN_BITS'(1)) begin
                    res_valid          = 1'b1;
                    res.status         = ST_DONE;
                    res.content_length = LENGTH_BITS'(32'(acc_reg));
                    res.content_offset = OFFSET_BITS'(start_reg);
                    phase_next         = PH_TAG;
                end else if (last) begin
                    res_valid  = 1'b1;
                    res.status = ST_TRUNC;
                end
            end
            default: begin
                phase_next = PH_SKIP;
            end
        endcase

        if (known) begin
            start_next = pos_inc;
            if (known_len == '0) begin
                res_valid          = 1'b1;
                res.status         = ST_DONE;
                res.content_offset = OFFSET_BITS'(pos_inc);
                phase_next         = PH_TAG;
            end else begin
                left_next  = known_len;
                phase_next = PH_CONTENT;
                if (last) begin
                    res_valid  = 1'b1;
                    res.status = ST_TRUNC;
                end
            end
        end

        if (last) begin
            phase_next = PH_TAG;
            pos_next   = '0;
        end else begin
            pos_next = pos_inc;
        end

        res.tag   = tag_next;
        res_valid = res_valid && fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TAG;
            tag_reg   <= '0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    a_last_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && last |=> phase_reg == PH_TAG && pos_reg == '0)
        else $error("buffer end did not rewind parser");

    a_skip_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg == PH_SKIP |-> !res_valid)
        else $error("result while skipping");

    a_trunc_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == ST_TRUNC |-> last && fire)
        else $error("truncation away from buffer end");

    a_content_done: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg == PH_CONTENT && left_reg == LEN_BITS'(1)
        |-> res_valid && res.status == ST_DONE)
        else $error("element completion missed");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the BER TLV stream parser
// Streams byte buffers through the parser with random gaps and back-pressure.
// A local parser model predicts each report (element complete, truncation,
// unsupported length), and a scoreboard compares every field of every report.
// ----------------------------------------------------------------------------
module tb_top;
    import btlv_pkg::*;

    localparam int MAX_LEN_BYTES = MAX_LENGTH_BYTES_DEF;

    typedef enum logic [2:0] {
        AWAIT_TAG,
        AWAIT_LEN,
        IN_LEN_BYTES,
        IN_CONTENT,
        DISCARD
    } hdr_phase_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] data_byte
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // [7:0] tag, [38:8] content_length, [54:39] content_offset
    logic [1:0]  m_tuser;           // [1:0] status
    logic        m_tlast;

    // parser model state
    hdr_phase_t  hdr_phase     = AWAIT_TAG;
    logic [7:0]  cur_tag       = 8'd0;
    logic [2:0]  len_bytes_due = 3'd0;
    logic [31:0] len_value     = 32'd0;
    logic [31:0] content_due   = 32'd0;
    logic [15:0] pos           = 16'd0;
    logic [15:0] content_start = 16'd0;

    result_t due_reports[$];
    bit      idle_on     = 1'b1;
    int      ready_hold  = 0;
    int      mismatches  = 0;
    int      reports_seen = 0;
    int      bytes_sent  = 0;
    int      frames_sent = 0;
    int      n_done      = 0;
    int      n_trunc     = 0;
    int      n_unsup     = 0;

    ber_tlv_stream_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        #10_000_000;
        $display("timeout: %0d reports still pending", due_reports.size());
        $display("tb_top failed");
        $finish;
    end

    function automatic void queue_report(status_t st, logic [30:0] len, logic [15:0] off,
                                         logic fin);
        result_t r;
        r.status         = st;
        r.tag            = cur_tag;
        r.content_length = len;
        r.content_offset = off;
        r.buffer_end     = fin;
        due_reports.insert(due_reports.size(), r);
    endfunction

    function automatic void close_length(logic [15:0] here, logic fin);
        content_start = here + 16'd1;
        if (len_value == 32'd0) begin
            queue_report(ST_DONE, '0, content_start, fin);
            hdr_phase = AWAIT_TAG;
        end else begin
            content_due = len_value;
            hdr_phase   = IN_CONTENT;
            if (fin) queue_report(ST_TRUNC, '0, '0, 1'b1);
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic fin);
        logic [15:0] here;
        here = pos;
        case (hdr_phase)
            AWAIT_TAG: begin
                cur_tag   = b;
                hdr_phase = AWAIT_LEN;
                if (fin) queue_report(ST_TRUNC, '0, '0, 1'b1);
            end
            AWAIT_LEN: begin
                if (b < LONG_FORM_MARK) begin
                    len_value = {24'd0, b};
                    close_length(here, fin);
                end else if (b == LONG_FORM_MARK || b > LONG_FORM_MARK + MAX_LEN_BYTES) begin
                    queue_report(ST_UNSUP, '0, '0, fin);
                    hdr_phase = DISCARD;
                end else begin
                    len_bytes_due = 3'(b - LONG_FORM_MARK);
                    len_value     = 32'd0;
                    hdr_phase     = IN_LEN_BYTES;
                    if (fin) queue_report(ST_TRUNC, '0, '0, 1'b1);
                end
            end
            IN_LEN_BYTES: begin
                len_value     = {len_value[23:0], b};
                len_bytes_due = len_bytes_due - 3'd1;
                if (len_bytes_due == 3'd0) begin
                    if (len_value[31]) begin
                        queue_report(ST_UNSUP, '0, '0, fin);
                        hdr_phase = DISCARD;
                    end else begin
                        close_length(here, fin);
                    end
                end else if (fin) begin
                    queue_report(ST_TRUNC, '0, '0, 1'b1);
                end
            end
            IN_CONTENT: begin
                content_due = content_due - 32'd1;
                if (content_due == 32'd0) begin
                    queue_report(ST_DONE, len_value[30:0], content_start, fin);
                    hdr_phase = AWAIT_TAG;
                end else if (fin) begin
                    queue_report(ST_TRUNC, '0, '0, 1'b1);
                end
            end
            default: hdr_phase = DISCARD;
        endcase
        if (fin) begin
            hdr_phase = AWAIT_TAG;
            pos       = 16'd0;
        end else begin
            pos = here + 16'd1;
        end
    endfunction

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("mismatch in report %0d: %s got 0x%0h want 0x%0h",
                 reports_seen, what, got, want);
    endtask

    // enter and leave at a falling edge
    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b, fin);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] frame[$]);
        for (int i = 0; i < frame.size(); i++) begin
            send_byte(frame[i], i == frame.size() - 1);
        end
        frames_sent++;
    endtask

    task automatic append_element(ref logic [7:0] frame[$]);
        int len;
        int nlen;
        frame.insert(frame.size(), 8'($urandom));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
        if (len < 128 && $urandom_range(0, 2) != 0) begin
            frame.insert(frame.size(), 8'(len));
        end else begin
            nlen = $urandom_range(len < 256 ? 1 : 2, MAX_LEN_BYTES);
            frame.insert(frame.size(), LONG_FORM_MARK + 8'(nlen));
            for (int i = nlen - 1; i >= 0; i--) frame.insert(frame.size(), 8'(len >> (8 * i)));
        end
        repeat (len) frame.insert(frame.size(), 8'($urandom));
    endtask

    task automatic test_short_form();
        logic [7:0] f[$];
        idle_on = 1'b1;
        f = {8'h02, 8'h01, 8'hFF, 8'h30, 8'h00, 8'h00, 8'h02, 8'h00, 8'h7F};
        send_frame(f);
    endtask

    task automatic test_long_form();
        logic [7:0] f[$];
        idle_on = 1'b0;
        f = {8'h04, 8'h81, 8'h01, 8'hA5, 8'hFF, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5A};
        send_frame(f);
    endtask

    task automatic test_unsupported_length();
        logic [7:0] f[$];
        idle_on = 1'b1;
        f = {8'h30, 8'h80, 8'h02, 8'h00};
        send_frame(f);
        f = {8'h31, 8'hFF};
        send_frame(f);
        f = {8'h32, 8'h84, 8'h80, 8'h00, 8'h00, 8'h00};
        send_frame(f);
    endtask

    task automatic test_truncation();
        logic [7:0] f[$];
        idle_on = 1'b1;
        f = {8'h1F};
        send_frame(f);
        f = {8'h1F, 8'h82};
        send_frame(f);
        f = {8'h1F, 8'h82, 8'h01};
        send_frame(f);
        f = {8'h1F, 8'h03};
        send_frame(f);
        f = {8'h1F, 8'h84, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hAA};
        send_frame(f);
    endtask

    task automatic test_random_buffers();
        logic [7:0] f[$];
        int kind;
        int cut;
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < 2000) begin
            f = {};
            idle_on = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 24)) f.insert(f.size(), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 5)) append_element(f);
                if (kind <= 2) begin
                    cut = $urandom_range(1, f.size());
                    while (f.size() > cut) void'(f.pop_back());
                end else if (kind <= 4) begin
                    // append a header with an unsupported length, then junk
                    f.insert(f.size(), 8'($urandom));
                    case ($urandom_range(0, 2))
                        0: f.insert(f.size(), LONG_FORM_MARK);
                        1: f.insert(f.size(), 8'($urandom_range(8'h85, 8'hFF)));
                        default: begin
                            f.insert(f.size(), LONG_FORM_MARK + 8'(MAX_LEN_BYTES));
                            f.insert(f.size(), 8'h80 | 8'($urandom));
                            repeat (3) f.insert(f.size(), 8'($urandom));
                        end
                    endcase
                    repeat ($urandom_range(0, 6)) f.insert(f.size(), 8'($urandom));
                end
            end
            send_frame(f);
        end
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            reports_seen++;
            ready_hold = idle_on ? $urandom_range(0, 11) : 0;
            if (due_reports.size() == 0) begin
                flag_mismatch("report with none pending, tdata", m_tdata, 0);
            end else begin
                want = due_reports.pop_front();
                if (m_tuser != want.status) flag_mismatch("status", m_tuser, want.status);
                if (m_tdata[7:0] != want.tag) flag_mismatch("tag", m_tdata[7:0], want.tag);
                if (m_tdata[38:8] != want.content_length)
                    flag_mismatch("content_length", m_tdata[38:8], want.content_length);
                if (m_tdata[54:39] != want.content_offset)
                    flag_mismatch("content_offset", m_tdata[54:39], want.content_offset);
                if (m_tlast != want.buffer_end)
                    flag_mismatch("buffer_end", m_tlast, want.buffer_end);
                case (want.status)
                    ST_DONE:  n_done++;
                    ST_TRUNC: n_trunc++;
                    default:  n_unsup++;
                endcase
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_short_form();
        test_long_form();
        test_unsupported_length();
        test_truncation();
        test_random_buffers();
        s_tvalid <= 1'b0;
        while (due_reports.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        $display("%0d bytes in %0d buffers, %0d reports checked", bytes_sent, frames_sent,
                 reports_seen);
        $display("complete %0d, truncated %0d, unsupported %0d, mismatches %0d",
                 n_done, n_trunc, n_unsup, mismatches);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/btlv_pkg.sv
src/btlv_stage.sv
src/btlv_core.sv
src/ber_tlv_stream_parser_unit.sv
dv/tb_top.sv
